/* rtl/shcb_pkg.sv */
// Shared widths, defaults and the front-to-back queue entry of the Huffman code builder.
package shcb_pkg;

    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int SYM_W           = 8;
    localparam int FREQ_W          = 16;
    localparam int CODE_W          = 15;
    localparam int LEN_W           = 4;
    localparam int LEN_MAX         = 15;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [FREQ_W-1:0] frequency;
        logic              last;
        logic              keep;
    } t_q_item;

endpackage

/* rtl/shcb_in_if.sv */
// Request channel carrying one symbol and its frequency.
interface shcb_in_if;
    import shcb_pkg::*;

    logic              valid;
    logic              ready;
    logic [SYM_W-1:0]  symbol;
    logic [FREQ_W-1:0] frequency;
    logic              last_symbol;

    modport source(output valid, output symbol, output frequency, output last_symbol,
                   input ready);
    modport sink(input valid, input symbol, input frequency, input last_symbol,
                 output ready);
endinterface

/* rtl/shcb_out_if.sv */
// Result channel carrying one symbol with its code and length.
interface shcb_out_if;
    import shcb_pkg::*;

    logic              valid;
    logic              ready;
    logic [SYM_W-1:0]  code_symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              last_code;

    modport source(output valid, output code_symbol, output code_bits,
                   output code_length, output last_code, input ready);
    modport sink(input valid, input code_symbol, input code_bits,
                 input code_length, input last_code, output ready);
endinterface

/* rtl/shcb_front.sv */
// Front end: accept requests, mark overflow symbols, buffer them in a two-entry queue.
module shcb_front #(
    parameter int MAX_SYMBOLS = shcb_pkg::MAX_SYMBOLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    shcb_in_if.sink           i_in,
    output logic              o_q_valid,
    output shcb_pkg::t_q_item o_q_item,
    input  logic              i_q_ready
);
    import shcb_pkg::*;

    localparam int CW = $clog2(MAX_SYMBOLS + 1);

    t_q_item       r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_fill;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;
    t_q_item       w_item;

    assign i_in.ready = (r_fill != 2'd2);
    assign w_push     = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_fill != 2'd0);
    assign w_pop      = o_q_valid && i_q_ready;
    assign o_q_item   = r_mem[r_rp];

    always_comb begin
        w_item.symbol    = i_in.symbol;
        w_item.frequency = i_in.frequency;
        w_item.last      = i_in.last_symbol;
        w_item.keep      = (r_cnt < CW'(MAX_SYMBOLS));
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
                // count symbols of the current set, saturate when full
                if (i_in.last_symbol) begin
                    r_cnt <= '0;
                end else if (w_item.keep) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_fill <= r_fill + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

/* rtl/shcb_back.sv */
// Back end: store leaves, merge with two queues, walk the tree and emit codes.
module shcb_back #(
    parameter int MAX_SYMBOLS = shcb_pkg::MAX_SYMBOLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  shcb_pkg::t_q_item i_q_item,
    output logic              o_q_ready,
    shcb_out_if.source        o_out
);
    import shcb_pkg::*;

    localparam int IW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int CW = $clog2(MAX_SYMBOLS + 1);
    localparam int WW = FREQ_W + IW;
    localparam int NW = IW + 1;     // node id: merged flag and index
    localparam int DW = IW;

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_TAKE_A = 3'd1;
    localparam logic [2:0] ST_TAKE_B = 3'd2;
    localparam logic [2:0] ST_INIT   = 3'd3;
    localparam logic [2:0] ST_POP    = 3'd4;
    localparam logic [2:0] ST_PUSH   = 3'd5;

    logic [SYM_W-1:0]  r_leaf_sym [MAX_SYMBOLS];
    logic [FREQ_W-1:0] r_leaf_w   [MAX_SYMBOLS];
    logic [WW-1:0]     r_merged_w [MAX_SYMBOLS];
    logic [NW-1:0]     r_child_l  [MAX_SYMBOLS];
    logic [NW-1:0]     r_child_r  [MAX_SYMBOLS];
    logic [NW-1:0]     r_stk_node [MAX_SYMBOLS];
    logic [DW-1:0]     r_stk_dep  [MAX_SYMBOLS];
    logic [CODE_W-1:0] r_stk_code [MAX_SYMBOLS];

    logic [2:0]        r_state;
    logic [CW-1:0]     r_n, r_lh, r_mh, r_mt, r_sp;
    logic [NW-1:0]     r_a, r_pl;
    logic [WW-1:0]     r_wa;
    logic [DW-1:0]     r_pd;
    logic [CODE_W-1:0] r_pc;

    logic              r_o_valid, r_o_last;
    logic [SYM_W-1:0]  r_o_sym;
    logic [CODE_W-1:0] r_o_bits;
    logic [LEN_W-1:0]  r_o_len;

    logic              w_leaf_ok, w_merg_ok, w_take_leaf;
    logic [IW-1:0]     w_lh_idx, w_mh_idx, w_top, w_k;
    logic [WW-1:0]     w_leaf_wx, w_merg_w, w_take_w;
    logic [NW-1:0]     w_take_id, w_node;
    logic [CW:0]       w_remain;
    logic              w_out_free;
    logic [DW-1:0]     w_dep;
    logic [CODE_W-1:0] w_code;

    assign o_q_ready         = (r_state == ST_LOAD);
    assign o_out.valid       = r_o_valid;
    assign o_out.code_symbol = r_o_sym;
    assign o_out.code_bits   = r_o_bits;
    assign o_out.code_length = r_o_len;
    assign o_out.last_code   = r_o_last;
    assign w_out_free        = !r_o_valid || o_out.ready;

    // pick the smaller front, merged queue on a tie
    always_comb begin
        w_lh_idx    = r_lh[IW-1:0];
        w_mh_idx    = r_mh[IW-1:0];
        w_leaf_ok   = (r_lh < r_n);
        w_merg_ok   = (r_mh < r_mt);
        w_leaf_wx   = WW'(r_leaf_w[w_lh_idx]);
        w_merg_w    = r_merged_w[w_mh_idx];
        w_take_leaf = w_leaf_ok && (!w_merg_ok || (w_leaf_wx < w_merg_w));
        w_take_id   = w_take_leaf ? {1'b0, w_lh_idx} : {1'b1, w_mh_idx};
        w_take_w    = w_take_leaf ? w_leaf_wx : w_merg_w;
        w_remain    = (CW + 1)'(r_n - r_lh) + (CW + 1)'(r_mt - r_mh);
        w_top       = IW'(r_sp - CW'(1));
        w_node      = r_stk_node[w_top];
        w_dep       = r_stk_dep[w_top];
        w_code      = r_stk_code[w_top];
        w_k         = w_node[IW-1:0];
    end

    // storage writes
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LOAD: begin
                if (i_q_valid && i_q_item.keep) begin
                    r_leaf_sym[r_n[IW-1:0]] <= i_q_item.symbol;
                    r_leaf_w[r_n[IW-1:0]]   <= i_q_item.frequency;
                end
            end
            ST_TAKE_A: begin
                r_a  <= w_take_id;
                r_wa <= w_take_w;
            end
            ST_TAKE_B: begin
                r_child_l[r_mt[IW-1:0]]  <= r_a;
                r_child_r[r_mt[IW-1:0]]  <= w_take_id;
                r_merged_w[r_mt[IW-1:0]] <= r_wa + w_take_w;
            end
            ST_INIT: begin
                r_stk_node[0] <= (r_mt == '0) ? '0 : {1'b1, IW'(r_mt - CW'(1))};
                r_stk_dep[0]  <= '0;
                r_stk_code[0] <= '0;
            end
            ST_POP: begin
                if (r_sp != '0) begin
                    if (w_node[NW-1]) begin
                        // replace top with right child, hold left child for the push
                        r_stk_node[w_top] <= r_child_r[w_k];
                        r_stk_dep[w_top]  <= w_dep + DW'(1);
                        r_stk_code[w_top] <= {w_code[CODE_W-2:0], 1'b1};
                        r_pl <= r_child_l[w_k];
                        r_pd <= w_dep + DW'(1);
                        r_pc <= {w_code[CODE_W-2:0], 1'b0};
                    end else if (w_out_free) begin
                        r_o_sym  <= r_leaf_sym[w_k];
                        r_o_bits <= w_code;
                        r_o_len  <= (32'(w_dep) > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(w_dep);
                        r_o_last <= (r_sp == CW'(1));
                    end
                end
            end
            ST_PUSH: begin
                r_stk_node[r_sp[IW-1:0]] <= r_pl;
                r_stk_dep[r_sp[IW-1:0]]  <= r_pd;
                r_stk_code[r_sp[IW-1:0]] <= r_pc;
            end
            default: begin
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_n       <= '0;
            r_lh      <= '0;
            r_mh      <= '0;
            r_mt      <= '0;
            r_sp      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_LOAD: begin
                    if (i_q_valid) begin
                        if (i_q_item.keep) begin
                            r_n <= r_n + CW'(1);
                        end
                        if (i_q_item.last) begin
                            r_lh    <= '0;
                            r_mh    <= '0;
                            r_mt    <= '0;
                            r_state <= ST_TAKE_A;
                        end
                    end
                end
                ST_TAKE_A: begin
                    if (w_remain > (CW + 1)'(1)) begin
                        if (w_take_leaf) r_lh <= r_lh + CW'(1);
                        else             r_mh <= r_mh + CW'(1);
                        r_state <= ST_TAKE_B;
                    end else begin
                        r_state <= ST_INIT;
                    end
                end
                ST_TAKE_B: begin
                    if (w_take_leaf) r_lh <= r_lh + CW'(1);
                    else             r_mh <= r_mh + CW'(1);
                    r_mt    <= r_mt + CW'(1);
                    r_state <= ST_TAKE_A;
                end
                ST_INIT: begin
                    r_sp    <= CW'(1);
                    r_state <= ST_POP;
                end
                ST_POP: begin
                    if (r_sp == '0) begin
                        r_n     <= '0;
                        r_state <= ST_LOAD;
                    end else if (w_node[NW-1]) begin
                        r_state <= ST_PUSH;
                    end else if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_sp      <= r_sp - CW'(1);
                    end
                end
                ST_PUSH: begin
                    r_sp    <= r_sp + CW'(1);
                    r_state <= ST_POP;
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end
endmodule

/* rtl/sorted_huffman_code_builder_unit.sv */
// Top level of the two-queue Huffman code builder: front queue and build/walk engine.
//
// Send symbols with nondecreasing frequencies, one request each, and mark the
// final one with last_symbol; that request starts the build. The block then
// returns one code per stored symbol, leaves in left-to-right tree order,
// with last_code on the final one. Symbols beyond MAX_SYMBOLS in a set are
// dropped, although a dropped request marked last still starts the build.
// After loading, the build engine performs the n - 1 merges, seeds the walk
// with the root and walks the tree, emitting one code per leaf and descending
// through each internal node; a stalled result port stretches the walk. A two-entry
// request queue lets the next set start arriving while the walk is running.
module sorted_huffman_code_builder_unit #(
    parameter int MAX_SYMBOLS = shcb_pkg::MAX_SYMBOLS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    shcb_in_if.sink    i_in,
    shcb_out_if.source o_out
);
    import shcb_pkg::*;

    // queue between the front and the engine
    logic    w_q_valid;
    logic    w_q_ready;
    t_q_item w_q_item;

    shcb_front #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_q_valid(w_q_valid),
        .o_q_item (w_q_item),
        .i_q_ready(w_q_ready)
    );

    shcb_back #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(w_q_valid),
        .i_q_item (w_q_item),
        .o_q_ready(w_q_ready),
        .o_out    (o_out)
    );
endmodule

/* tb/sv/tb_sorted_huffman_code_builder_unit.sv */
// Testbench for the Huffman code builder: symbol-set requests, predicted codes, checked results.
`timescale 1ns / 100ps

module tb_sorted_huffman_code_builder_unit;
    import shcb_pkg::*;

    localparam int NSYM      = MAX_SYMBOLS_DEF;
    localparam int CYCLE_CAP = 1000000;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  length;
        logic              last;
    } t_code;

    // Scoreboard: holds the loaded set, predicts the code burst when the set
    // closes and checks each returned code against the oldest prediction.
    class code_scoreboard;
        logic [SYM_W-1:0] set_sym[NSYM];
        int unsigned      set_wt[NSYM];
        int unsigned      set_count;
        t_code            pending[$];
        int unsigned      errors;
        int unsigned      codes_seen;
        int unsigned      sets_built;

        function void note_request(logic [SYM_W-1:0] sym, logic [FREQ_W-1:0] freq,
                                   logic closes);
            int unsigned mw[NSYM], mid[NSYM], lc[NSYM], rc[NSYM];
            int unsigned snode[2*NSYM], sdep[2*NSYM], scode[2*NSYM];
            int unsigned n, lh, mh, mt, sp, cnt, pick, wsum, node, d, c, k;
            t_code burst[$];
            t_code item;
            if (set_count < NSYM) begin
                set_sym[set_count] = sym;
                set_wt[set_count]  = freq;
                set_count++;
            end
            if (!closes) return;
            n = set_count; lh = 0; mh = 0; mt = 0;
            while ((n - lh) + (mt - mh) > 1 && mt < NSYM) begin
                wsum = 0;
                for (int t = 0; t < 2; t++) begin
                    // take the leaf only when strictly lighter; ties go to merged
                    if (lh < n && (mh >= mt || set_wt[lh] < mw[mh])) begin
                        pick = lh; wsum += set_wt[lh]; lh++;
                    end else begin
                        pick = mid[mh]; wsum += mw[mh]; mh++;
                    end
                    if (t == 0) lc[mt] = pick; else rc[mt] = pick;
                end
                mw[mt] = wsum; mid[mt] = n + mt; mt++;
            end
            snode[0] = (mt == 0) ? 0 : mid[mt-1]; sdep[0] = 0; scode[0] = 0;
            sp = 1; cnt = 0;
            while (sp > 0 && cnt < NSYM) begin
                sp--;
                node = snode[sp]; d = sdep[sp]; c = scode[sp];
                if (node < n) begin
                    item.symbol = set_sym[node];
                    item.bits   = c[CODE_W-1:0];
                    item.length = (d > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(d);
                    item.last   = 1'b0;
                    burst.push_back(item);
                    cnt++;
                end else begin
                    k = (node - n) % NSYM;
                    if (sp + 2 <= 2*NSYM) begin
                        snode[sp] = rc[k]; sdep[sp] = d + 1; scode[sp] = (c << 1) | 1;
                        snode[sp+1] = lc[k]; sdep[sp+1] = d + 1; scode[sp+1] = c << 1;
                        sp += 2;
                    end
                end
            end
            if (cnt > 0) burst[cnt-1].last = 1'b1;
            foreach (burst[i]) pending.push_back(burst[i]);
            set_count = 0;
            sets_built++;
        endfunction

        function void check_code(t_code got);
            t_code want;
            codes_seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected code sym=%0h bits=%0h len=%0d last=%0b", $time,
                         got.symbol, got.bits, got.length, got.last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.symbol !== want.symbol) begin
                $display("%0t: code_symbol expected %0h actual %0h", $time, want.symbol,
                         got.symbol);
                errors++;
            end
            if (got.bits !== want.bits) begin
                $display("%0t: code_bits expected %0h actual %0h", $time, want.bits, got.bits);
                errors++;
            end
            if (got.length !== want.length) begin
                $display("%0t: code_length expected %0d actual %0d", $time, want.length,
                         got.length);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last_code expected %0b actual %0b", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    shcb_in_if  req_ch();
    shcb_out_if res_ch();

    sorted_huffman_code_builder_unit i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch.sink),
        .o_out  (res_ch.source)
    );

    code_scoreboard codes;
    int unsigned    send_idle_pct;
    int unsigned    recv_idle_pct;
    bit             hold_results;
    int unsigned    cycle_count = 0;
    int unsigned    requests_sent;

    always #10 i_clk = ~i_clk;

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sample results at the rising edge; note accepted requests likewise.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            codes.check_code({res_ch.code_symbol, res_ch.code_bits, res_ch.code_length,
                              res_ch.last_code});
        if (i_rst_n && req_ch.valid && req_ch.ready)
            codes.note_request(req_ch.symbol, req_ch.frequency, req_ch.last_symbol);
    end

    // Drive the result ready at the falling edge; a long hold-off blocks it.
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_results)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one request and hold it until accepted, with random idle gaps first.
    // Valid stays up after acceptance until the next request or an idle gap.
    task automatic send_request(logic [SYM_W-1:0] sym, logic [FREQ_W-1:0] freq,
                                logic closes);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.symbol      <= sym;
        req_ch.frequency   <= freq;
        req_ch.last_symbol <= closes;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        requests_sent++;
    endtask

    // Send one set: sorted weights unless asked otherwise, random content.
    task automatic send_set(int unsigned count, int unsigned wmax, bit sorted_wt);
        logic [FREQ_W-1:0] w;
        w = FREQ_W'($urandom_range(wmax));
        for (int unsigned i = 0; i < count; i++) begin
            send_request(SYM_W'($urandom_range(255)), w, i == count - 1);
            if (sorted_wt) begin
                if (w + 3000 < 65535 && wmax > 0)
                    w = FREQ_W'(w + $urandom_range(wmax > 3000 ? 3000 : wmax));
            end else begin
                w = FREQ_W'($urandom_range(wmax));
            end
        end
    endtask

    task automatic drain;
        req_ch.valid <= 1'b0;
        while (codes.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned sz;
        codes = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        requests_sent = 0;
        hold_results = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        req_ch.valid = 1'b0;
        req_ch.symbol = '0;
        req_ch.frequency = '0;
        req_ch.last_symbol = 1'b0;
        res_ch.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single symbol, two symbols, field extremes, equal weights.
        send_request(8'h00, 16'h0000, 1'b1);
        send_request(8'hFF, 16'hFFFF, 1'b1);
        send_request(8'h00, 16'h0000, 1'b0);
        send_request(8'hFF, 16'hFFFF, 1'b1);
        send_request(8'h55, 16'h5555, 1'b0);
        send_request(8'hAA, 16'hAAAA, 1'b1);
        for (int i = 0; i < 4; i++) send_request(SYM_W'(i), 16'd7, i == 3);
        // Fibonacci weights give the deepest tree (codes up to 15 bits).
        begin
            int unsigned fa, fb, ft;
            fa = 1; fb = 1;
            for (int i = 0; i < 17; i++) begin
                // the last item overflows the set and closes it
                send_request(SYM_W'(8'h10 + i), FREQ_W'(fa), i == 16);
                ft = fa + fb; fa = fb; fb = ft;
            end
        end
        drain();

        // Random sets; phases of idling on each side, then none.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 77 : 0;
            recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 21 : 0;
            while (requests_sent < 25 + (ph + 1) * 130) begin
                sz = ($urandom_range(9) == 0) ? $urandom_range(NSYM, NSYM + 3)
                                              : $urandom_range(1, 8);
                case ($urandom_range(5))
                    0: send_set(sz, 65535, 1'b0);     // unsorted noise
                    1: send_set(sz, 3, 1'b1);         // many ties
                    default: send_set(sz, 2000, 1'b1);
                endcase
                if (ph == 1 && $urandom_range(7) == 0) drain();
            end
            if (ph == 0) begin
                // Long result hold-off while requests keep coming.
                fork
                    begin
                        hold_results = 1'b1;
                        repeat (600) @(posedge i_clk);
                        hold_results = 1'b0;
                    end
                    for (int s = 0; s < 4; s++) send_set(NSYM, 2000, 1'b1);
                join
            end
            drain();
        end

        $display("Ran %0d requests in %0d symbol sets, %0d codes checked,",
                 requests_sent, codes.sets_built, codes.codes_seen);
        $display("covering single-symbol, overflowing, tied, unsorted and deep-code sets.");
        if (codes.errors == 0 && codes.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
